### hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked property that also holds across reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/cptc_pkg.sv
package cptc_pkg;

  // Field widths
  localparam int OpW     = 3;
  localparam int JobW    = 32;
  localparam int TimeW   = 32;
  localparam int TgtW    = 24;
  localparam int PhaseW  = 2;
  localparam int CountW  = 7;
  localparam int CursorW = 6;
  localparam int CycleW  = 22;
  localparam int IntvW   = 16;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 32;

  localparam int CapacityDefault = 64;

  // Opcodes
  localparam logic [OpW-1:0] OP_BEGIN  = 3'd0;
  localparam logic [OpW-1:0] OP_ADD    = 3'd1;
  localparam logic [OpW-1:0] OP_FREEZE = 3'd2;
  localparam logic [OpW-1:0] OP_NEXT   = 3'd3;
  localparam logic [OpW-1:0] OP_POLL   = 3'd4;

  // Campaign phases
  localparam logic [PhaseW-1:0] PH_IDLE    = 2'd0;
  localparam logic [PhaseW-1:0] PH_GATHER  = 2'd1;
  localparam logic [PhaseW-1:0] PH_FROZEN  = 2'd2;
  localparam logic [PhaseW-1:0] PH_EXPIRED = 2'd3;

  // Configuration register indexes and reset values
  localparam logic [CfgIdxW-1:0] CFG_INTERVAL = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DUR  = 1'd1;
  localparam logic [IntvW-1:0]   IntervalRst  = 16'd250;
  localparam logic [TimeW-1:0]   MaxDurRst    = 32'd600000;

  typedef struct packed {
    logic [IntvW-1:0] interval;
    logic [TimeW-1:0] max_dur;
  } cfg_t;

  typedef struct packed {
    logic               ok;
    logic [TgtW-1:0]    target;
    logic [PhaseW-1:0]  phase;
    logic [JobW-1:0]    job;
    logic [CountW-1:0]  count;
    logic [CursorW-1:0] cursor;
    logic [31:0]        total;
    logic [TimeW-1:0]   remaining;
    logic [CycleW-1:0]  cycle;
  } res_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_DONE  = 5'b10000
  } st_t;

endpackage

### hdl/paced_round_robin_target_campaign_core.sv
// Campaign engine: begin, add, freeze, next and status poll requests each
// give one result word. The block takes one request at a time; a request
// is taken while a previous result still waits in the output register.
// Begin, freeze, status poll and unused opcodes go straight from the
// execute state to the result state; next adds one read of the target
// table, and add to a table holding N targets runs a duplicate check that
// reads up to N table entries, one entry per cycle, through its
// single read port. The table needs no clearing after reset or begin:
// only entries below the stored count are ever read.
module paced_round_robin_target_campaign_core #(
  parameter int CAPACITY = cptc_pkg::CapacityDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cptc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [cptc_pkg::CfgW-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cptc_pkg::OpW-1:0]        in_opcode,
  input  logic [cptc_pkg::JobW-1:0]       in_job_id,
  input  logic [cptc_pkg::TimeW-1:0]      in_duration_ms,
  input  logic [cptc_pkg::TimeW-1:0]      in_now_ms,
  input  logic [cptc_pkg::TgtW-1:0]       in_target_addr,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_ok,
  output logic [cptc_pkg::TgtW-1:0]       out_target_out,
  output logic [cptc_pkg::PhaseW-1:0]     out_phase,
  output logic [cptc_pkg::JobW-1:0]       out_job_out,
  output logic [cptc_pkg::CountW-1:0]     out_target_count,
  output logic [cptc_pkg::CursorW-1:0]    out_cursor_out,
  output logic [31:0]                     out_dispatch_total,
  output logic [cptc_pkg::TimeW-1:0]      out_remaining_ms,
  output logic [cptc_pkg::CycleW-1:0]     out_cycle_ms
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  cptc_pkg::cfg_t cfg_r, cfg_nxt;
  cptc_pkg::res_t res;

  logic                      mem_wr_en;
  logic [IW-1:0]             mem_wr_addr;
  logic [cptc_pkg::TgtW-1:0] mem_wr_data;
  logic                      mem_rd_en;
  logic [IW-1:0]             mem_rd_addr;
  logic [cptc_pkg::TgtW-1:0] mem_rd_data;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        cptc_pkg::CFG_INTERVAL: cfg_nxt.interval = cfg_wdata[cptc_pkg::IntvW-1:0];
        cptc_pkg::CFG_MAX_DUR:  cfg_nxt.max_dur  = cfg_wdata[cptc_pkg::TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interval <= cptc_pkg::IntervalRst;
      cfg_r.max_dur  <= cptc_pkg::MaxDurRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cptc_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_i          (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_job_id      (in_job_id),
    .in_duration_ms (in_duration_ms),
    .in_now_ms      (in_now_ms),
    .in_target_addr (in_target_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_res        (res),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  cptc_tbl #(
    .DEPTH(CAPACITY)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Unpack the result word
  assign out_ok             = res.ok;
  assign out_target_out     = res.target;
  assign out_phase          = res.phase;
  assign out_job_out        = res.job;
  assign out_target_count   = res.count;
  assign out_cursor_out     = res.cursor;
  assign out_dispatch_total = res.total;
  assign out_remaining_ms   = res.remaining;
  assign out_cycle_ms       = res.cycle;

endmodule

### hdl/cptc_tbl.sv
module cptc_tbl #(
  parameter int DEPTH = cptc_pkg::CapacityDefault,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [cptc_pkg::TgtW-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [cptc_pkg::TgtW-1:0] rd_data
);

  logic [cptc_pkg::TgtW-1:0] mem_r [DEPTH];
  logic [cptc_pkg::TgtW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/cptc_seq.sv
module cptc_seq #(
  parameter int CAPACITY = cptc_pkg::CapacityDefault,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cptc_pkg::cfg_t               cfg_i,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cptc_pkg::OpW-1:0]     in_opcode,
  input  logic [cptc_pkg::JobW-1:0]    in_job_id,
  input  logic [cptc_pkg::TimeW-1:0]   in_duration_ms,
  input  logic [cptc_pkg::TimeW-1:0]   in_now_ms,
  input  logic [cptc_pkg::TgtW-1:0]    in_target_addr,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cptc_pkg::res_t               out_res,
  output logic                         mem_wr_en,
  output logic [IW-1:0]                mem_wr_addr,
  output logic [cptc_pkg::TgtW-1:0]    mem_wr_data,
  output logic                         mem_rd_en,
  output logic [IW-1:0]                mem_rd_addr,
  input  logic [cptc_pkg::TgtW-1:0]    mem_rd_data
);

  cptc_pkg::st_t state_r, state_nxt;

  // Latched request word
  logic [cptc_pkg::OpW-1:0]   op_r;
  logic [cptc_pkg::JobW-1:0]  job_r;
  logic [cptc_pkg::TimeW-1:0] dur_r;
  logic [cptc_pkg::TimeW-1:0] now_r;
  logic [cptc_pkg::TgtW-1:0]  tgt_r;

  // Campaign state
  logic [cptc_pkg::JobW-1:0]   cur_job_r, cur_job_nxt;
  logic [cptc_pkg::TimeW-1:0]  deadline_r, deadline_nxt;
  logic [cptc_pkg::TimeW-1:0]  nextd_r, nextd_nxt;
  logic [31:0]                 dcnt_r, dcnt_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [IW-1:0]               cursor_r, cursor_nxt;
  logic [cptc_pkg::PhaseW-1:0] phase_r, phase_nxt;

  // Per-request working registers
  logic [IW-1:0]              scan_r, scan_nxt;
  logic                       ok_r, ok_nxt;
  logic [cptc_pkg::TgtW-1:0]  sent_r, sent_nxt;
  logic                       out_valid_r, out_valid_nxt;
  cptc_pkg::res_t             out_r, out_nxt;

  logic                        in_acc;
  logic                        out_free;
  logic [cptc_pkg::TimeW-1:0]  diff_dl;
  logic [cptc_pkg::TimeW-1:0]  diff_nd;
  logic [cptc_pkg::PhaseW-1:0] phase_chk;
  logic                        cursor_last;
  logic                        scan_last;
  logic [31:0]                 prod;

  assign in_acc   = in_valid && (state_r == cptc_pkg::ST_IDLE);
  assign in_stall = (state_r != cptc_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Wrap-safe time compares: bit 31 of the difference is the sign
  assign diff_dl   = now_r - deadline_r;
  assign diff_nd   = now_r - nextd_r;
  assign phase_chk = ((phase_r == cptc_pkg::PH_GATHER) && !diff_dl[31]) ?
                     cptc_pkg::PH_EXPIRED : phase_r;

  assign cursor_last = ((CW'(cursor_r) + CW'(1)) == count_r);
  assign scan_last   = ((CW'(scan_r) + CW'(1)) == count_r);

  // Cycle length: stored count times interval, low bits kept
  assign prod = 32'(count_r) * 32'(cfg_i.interval);

  always_comb begin
    state_nxt     = state_r;
    cur_job_nxt   = cur_job_r;
    deadline_nxt  = deadline_r;
    nextd_nxt     = nextd_r;
    dcnt_nxt      = dcnt_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    phase_nxt     = phase_r;
    scan_nxt      = scan_r;
    ok_nxt        = ok_r;
    sent_nxt      = sent_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = count_r[IW-1:0];
    mem_wr_data   = tgt_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;

    case (state_r)
      cptc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = cptc_pkg::ST_EXEC;
        end
      end

      cptc_pkg::ST_EXEC: begin
        ok_nxt    = 1'b0;
        sent_nxt  = '0;
        state_nxt = cptc_pkg::ST_DONE;
        case (op_r)
          cptc_pkg::OP_BEGIN: begin
            if (job_r != '0 && dur_r != '0 && dur_r <= cfg_i.max_dur) begin
              cur_job_nxt  = job_r;
              deadline_nxt = now_r + dur_r;
              nextd_nxt    = now_r;
              dcnt_nxt     = '0;
              count_nxt    = '0;
              cursor_nxt   = '0;
              phase_nxt    = cptc_pkg::PH_GATHER;
              ok_nxt       = 1'b1;
            end
          end
          cptc_pkg::OP_ADD: begin
            if (phase_r == cptc_pkg::PH_GATHER && job_r == cur_job_r && tgt_r != '0) begin
              if (count_r == '0) begin
                // Empty table: store at once
                mem_wr_en = 1'b1;
                count_nxt = CW'(1);
                ok_nxt    = 1'b1;
              end else begin
                // Start the duplicate scan at entry zero
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                scan_nxt    = '0;
                state_nxt   = cptc_pkg::ST_SCAN;
              end
            end
          end
          cptc_pkg::OP_FREEZE: begin
            phase_nxt = phase_chk;
            if (job_r != '0 && job_r == cur_job_r && phase_chk == cptc_pkg::PH_GATHER) begin
              phase_nxt    = cptc_pkg::PH_FROZEN;
              deadline_nxt = now_r;
              ok_nxt       = 1'b1;
            end
          end
          cptc_pkg::OP_NEXT: begin
            phase_nxt = phase_chk;
            if (phase_chk == cptc_pkg::PH_GATHER && count_r != '0 && !diff_nd[31]) begin
              // Fetch the entry under the cursor, then advance
              mem_rd_en   = 1'b1;
              mem_rd_addr = cursor_r;
              cursor_nxt  = cursor_last ? '0 : IW'(cursor_r + IW'(1));
              dcnt_nxt    = dcnt_r + 32'd1;
              nextd_nxt   = now_r + 32'(cfg_i.interval);
              ok_nxt      = 1'b1;
              state_nxt   = cptc_pkg::ST_FETCH;
            end
          end
          cptc_pkg::OP_POLL: begin
            phase_nxt = phase_chk;
            ok_nxt    = 1'b1;
          end
          default: begin
          end
        endcase
      end

      cptc_pkg::ST_SCAN: begin
        if (mem_rd_data == tgt_r) begin
          // Duplicate: accept, store nothing
          ok_nxt    = 1'b1;
          state_nxt = cptc_pkg::ST_DONE;
        end else if (scan_last) begin
          if (count_r < CW'(CAPACITY)) begin
            mem_wr_en = 1'b1;
            count_nxt = count_r + CW'(1);
            ok_nxt    = 1'b1;
          end
          state_nxt = cptc_pkg::ST_DONE;
        end else begin
          scan_nxt    = IW'(scan_r + IW'(1));
          mem_rd_en   = 1'b1;
          mem_rd_addr = IW'(scan_r + IW'(1));
        end
      end

      cptc_pkg::ST_FETCH: begin
        sent_nxt  = mem_rd_data;
        state_nxt = cptc_pkg::ST_DONE;
      end

      cptc_pkg::ST_DONE: begin
        // Load the result word once the output slot is free
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_nxt.ok       = ok_r;
          out_nxt.target   = sent_r;
          out_nxt.phase    = phase_r;
          out_nxt.job      = cur_job_r;
          out_nxt.count    = cptc_pkg::CountW'(count_r);
          out_nxt.cursor   = cptc_pkg::CursorW'(cursor_r);
          out_nxt.total    = dcnt_r;
          out_nxt.remaining = (phase_r == cptc_pkg::PH_GATHER) ?
                              (deadline_r - now_r) : '0;
          out_nxt.cycle    = prod[cptc_pkg::CycleW-1:0];
          state_nxt        = cptc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = cptc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and campaign state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cptc_pkg::ST_IDLE;
      cur_job_r   <= '0;
      deadline_r  <= '0;
      nextd_r     <= '0;
      dcnt_r      <= '0;
      count_r     <= '0;
      cursor_r    <= '0;
      phase_r     <= cptc_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_job_r   <= cur_job_nxt;
      deadline_r  <= deadline_nxt;
      nextd_r     <= nextd_nxt;
      dcnt_r      <= dcnt_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_opcode;
      job_r <= in_job_id;
      dur_r <= in_duration_ms;
      now_r <= in_now_ms;
      tgt_r <= in_target_addr;
    end
    scan_r <= scan_nxt;
    ok_r   <= ok_nxt;
    sent_r <= sent_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

### hdl/cptc_chk.sv
`include "assert_macros.svh"

module cptc_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_ok,
  input logic [cptc_pkg::TgtW-1:0]     out_target_out,
  input logic [cptc_pkg::PhaseW-1:0]   out_phase,
  input logic [cptc_pkg::JobW-1:0]     out_job_out,
  input logic [cptc_pkg::TimeW-1:0]    out_remaining_ms
);

  // Reset empties the output slot
  `CHK_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

  // A stalled result word holds
  `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_ok) && $stable(out_target_out) && $stable(out_job_out), "stalled result changed")

  // One request at a time: busy right after an accept
  `CHK_ASSERT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall |=> in_stall, "second word taken while busy")

  // A failed request dispatches nothing
  `CHK_ASSERT(a_fail_no_target, clk, rst_n, out_valid && !out_ok |-> out_target_out == '0, "target on failed request")

  // Remaining time only shows while gathering
  `CHK_ASSERT(a_remain_gather, clk, rst_n, out_valid && out_phase != cptc_pkg::PH_GATHER |-> out_remaining_ms == '0, "remaining time outside gather")

endmodule

bind paced_round_robin_target_campaign_core cptc_chk u_cptc_chk (.*);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 150;

  // Opcodes the block leaves unused
  localparam logic [cptc_pkg::OpW-1:0] OP_SPARE0 = 3'd5;
  localparam logic [cptc_pkg::OpW-1:0] OP_SPARE1 = 3'd6;
  localparam logic [cptc_pkg::OpW-1:0] OP_SPARE2 = 3'd7;

  // Tracks campaign state and holds the status words still owed by the block.
  class campaign_tracker;
    logic [cptc_pkg::TgtW-1:0]   targets [cptc_pkg::CapacityDefault];
    logic [cptc_pkg::JobW-1:0]   job;
    logic [cptc_pkg::TimeW-1:0]  deadline;
    logic [cptc_pkg::TimeW-1:0]  next_ok_ms;
    logic [cptc_pkg::TimeW-1:0]  max_dur;
    logic [cptc_pkg::IntvW-1:0]  interval;
    logic [cptc_pkg::PhaseW-1:0] cphase;
    logic [31:0]                 sends;
    int unsigned                 stored;
    int unsigned                 cursor;
    cptc_pkg::res_t              owed_status[$];
    int                          errors;

    function new();
      job = '0;
      deadline = '0;
      next_ok_ms = '0;
      sends = '0;
      stored = 0;
      cursor = 0;
      cphase = cptc_pkg::PH_IDLE;
      interval = cptc_pkg::IntervalRst;
      max_dur = cptc_pkg::MaxDurRst;
      errors = 0;
    endfunction

    function void set_reg(logic [cptc_pkg::CfgIdxW-1:0] idx, logic [cptc_pkg::CfgW-1:0] val);
      if (idx == cptc_pkg::CFG_INTERVAL) interval = val[cptc_pkg::IntvW-1:0];
      else if (idx == cptc_pkg::CFG_MAX_DUR) max_dur = val;
    endfunction

    // True when a - b is negative as a signed 32-bit value
    function bit is_behind(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
    endfunction

    function void expire(logic [cptc_pkg::TimeW-1:0] now);
      if (cphase == cptc_pkg::PH_GATHER && !is_behind(now, deadline))
        cphase = cptc_pkg::PH_EXPIRED;
    endfunction

    // Apply one accepted request word and queue the status word it yields.
    function void note_request(logic [cptc_pkg::OpW-1:0] op,
                               logic [cptc_pkg::JobW-1:0] req_job,
                               logic [cptc_pkg::TimeW-1:0] dur,
                               logic [cptc_pkg::TimeW-1:0] now,
                               logic [cptc_pkg::TgtW-1:0] tgt);
      cptc_pkg::res_t r;
      bit             dup;
      r = '0;
      case (op)
        cptc_pkg::OP_BEGIN: begin
          if (req_job != 0 && dur != 0 && dur <= max_dur) begin
            job = req_job;
            deadline = now + dur;
            next_ok_ms = now;
            sends = '0;
            stored = 0;
            cursor = 0;
            cphase = cptc_pkg::PH_GATHER;
            r.ok = 1'b1;
          end
        end
        cptc_pkg::OP_ADD: begin
          if (cphase == cptc_pkg::PH_GATHER && req_job == job && tgt != 0) begin
            dup = 1'b0;
            for (int i = 0; i < stored; i++)
              if (targets[i] == tgt) dup = 1'b1;
            if (dup) begin
              r.ok = 1'b1;
            end else if (stored < cptc_pkg::CapacityDefault) begin
              targets[stored] = tgt;
              stored++;
              r.ok = 1'b1;
            end
          end
        end
        cptc_pkg::OP_FREEZE: begin
          expire(now);
          if (req_job != 0 && req_job == job && cphase == cptc_pkg::PH_GATHER) begin
            cphase = cptc_pkg::PH_FROZEN;
            deadline = now;
            r.ok = 1'b1;
          end
        end
        cptc_pkg::OP_NEXT: begin
          expire(now);
          if (cphase == cptc_pkg::PH_GATHER && stored != 0 && !is_behind(now, next_ok_ms)) begin
            r.target = targets[cursor];
            cursor = (cursor + 1) % stored;
            sends = sends + 32'd1;
            next_ok_ms = now + 32'(interval);
            r.ok = 1'b1;
          end
        end
        cptc_pkg::OP_POLL: begin
          expire(now);
          r.ok = 1'b1;
        end
        default: ;
      endcase
      r.phase = cphase;
      r.job = job;
      r.count = cptc_pkg::CountW'(stored);
      r.cursor = cptc_pkg::CursorW'(cursor);
      r.total = sends;
      r.remaining = (cphase == cptc_pkg::PH_GATHER) ? deadline - now : '0;
      r.cycle = cptc_pkg::CycleW'(stored * interval);
      owed_status.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(cptc_pkg::res_t got);
      cptc_pkg::res_t want;
      if (owed_status.size() == 0) begin
        $error("status word with none expected");
        errors++;
        return;
      end
      want = owed_status.pop_front();
      compare_field("ok", 32'(want.ok), 32'(got.ok));
      compare_field("target_out", 32'(want.target), 32'(got.target));
      compare_field("phase", 32'(want.phase), 32'(got.phase));
      compare_field("job_out", want.job, got.job);
      compare_field("target_count", 32'(want.count), 32'(got.count));
      compare_field("cursor_out", 32'(want.cursor), 32'(got.cursor));
      compare_field("dispatch_total", want.total, got.total);
      compare_field("remaining_ms", want.remaining, got.remaining);
      compare_field("cycle_ms", 32'(want.cycle), 32'(got.cycle));
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [cptc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [cptc_pkg::CfgW-1:0]    cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [cptc_pkg::OpW-1:0]     in_opcode = '0;
  logic [cptc_pkg::JobW-1:0]    in_job_id = '0;
  logic [cptc_pkg::TimeW-1:0]   in_duration_ms = '0;
  logic [cptc_pkg::TimeW-1:0]   in_now_ms = '0;
  logic [cptc_pkg::TgtW-1:0]    in_target_addr = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_ok;
  logic [cptc_pkg::TgtW-1:0]    out_target_out;
  logic [cptc_pkg::PhaseW-1:0]  out_phase;
  logic [cptc_pkg::JobW-1:0]    out_job_out;
  logic [cptc_pkg::CountW-1:0]  out_target_count;
  logic [cptc_pkg::CursorW-1:0] out_cursor_out;
  logic [31:0]                  out_dispatch_total;
  logic [cptc_pkg::TimeW-1:0]   out_remaining_ms;
  logic [cptc_pkg::CycleW-1:0]  out_cycle_ms;

  campaign_tracker tracker = new();

  int          accepted = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          cycle_count = 0;
  logic [31:0] clock_ms = '0;
  logic [31:0] pace_ms = 32'(cptc_pkg::IntervalRst);
  logic [31:0] dur_cap = cptc_pkg::MaxDurRst;

  paced_round_robin_target_campaign_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_job_id         (in_job_id),
    .in_duration_ms    (in_duration_ms),
    .in_now_ms         (in_now_ms),
    .in_target_addr    (in_target_addr),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ok            (out_ok),
    .out_target_out    (out_target_out),
    .out_phase         (out_phase),
    .out_job_out       (out_job_out),
    .out_target_count  (out_target_count),
    .out_cursor_out    (out_cursor_out),
    .out_dispatch_total(out_dispatch_total),
    .out_remaining_ms  (out_remaining_ms),
    .out_cycle_ms      (out_cycle_ms)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drive the result stall: one long hold-off once, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else if (!hold_done && accepted >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Check each status word as it is taken
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_result({out_ok, out_target_out, out_phase, out_job_out,
                            out_target_count, out_cursor_out, out_dispatch_total,
                            out_remaining_ms, out_cycle_ms});
  end

  // Offer one request word, with random gaps ahead of it, until taken
  task automatic send_word(logic [cptc_pkg::OpW-1:0] op, logic [cptc_pkg::JobW-1:0] job,
                           logic [cptc_pkg::TimeW-1:0] dur, logic [cptc_pkg::TimeW-1:0] now,
                           logic [cptc_pkg::TgtW-1:0] tgt);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_opcode = op;
    in_job_id = job;
    in_duration_ms = dur;
    in_now_ms = now;
    in_target_addr = tgt;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_request(op, job, dur, now, tgt);
    accepted++;
  endtask

  // Drop valid and wait until every owed status word has come back
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.owed_status.size() > 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [cptc_pkg::CfgIdxW-1:0] idx, logic [cptc_pkg::CfgW-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic load_config(logic [cptc_pkg::IntvW-1:0] intv,
                             logic [cptc_pkg::TimeW-1:0] maxd);
    settle();
    write_reg(cptc_pkg::CFG_INTERVAL, cptc_pkg::CfgW'(intv));
    write_reg(cptc_pkg::CFG_MAX_DUR, maxd);
    pace_ms = 32'(intv);
    dur_cap = maxd;
  endtask

  function automatic logic [31:0] next_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return 32'd0;
    if (pick < 60) return $urandom_range(0, pace_ms);
    if (pick < 85) return pace_ms + $urandom_range(0, pace_ms);
    return $urandom_range(0, 5000);
  endfunction

  function automatic logic [31:0] pick_duration();
    logic [31:0] d;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) d = $urandom_range(1000, 200000);
    else if (pick < 80) d = $urandom_range(1, 3000);
    else d = $urandom_range(1, dur_cap);
    if (d > dur_cap) d = dur_cap;
    return d;
  endfunction

  function automatic logic [cptc_pkg::TgtW-1:0] rand_tgt();
    return cptc_pkg::TgtW'($urandom());
  endfunction

  task automatic run_directed();
    logic [31:0] t0;
    t0 = 32'd1000;
    send_word(cptc_pkg::OP_POLL, '0, '0, '0, '0);
    // rejected begins: zero job, zero duration, duration above the cap; then a valid begin at the cap
    send_word(cptc_pkg::OP_BEGIN, '0, 32'd100, t0, '0);
    send_word(cptc_pkg::OP_BEGIN, 32'd5, '0, t0, '0);
    send_word(cptc_pkg::OP_BEGIN, 32'd5, cptc_pkg::MaxDurRst + 32'd1, t0, '0);
    send_word(cptc_pkg::OP_BEGIN, 32'hFFFF_FFFF, cptc_pkg::MaxDurRst, t0, '0);
    // zero target, extreme targets, duplicate, wrong job
    send_word(cptc_pkg::OP_ADD, 32'hFFFF_FFFF, '0, t0, '0);
    send_word(cptc_pkg::OP_ADD, 32'hFFFF_FFFF, '0, t0, 24'hFF_FFFF);
    send_word(cptc_pkg::OP_ADD, 32'hFFFF_FFFF, '0, t0, 24'h00_0001);
    send_word(cptc_pkg::OP_ADD, 32'hFFFF_FFFF, '0, t0, 24'hFF_FFFF);
    send_word(cptc_pkg::OP_ADD, 32'd5, '0, t0, 24'h00_0002);
    // dispatch pacing: too early, on time, too early again, on time
    send_word(cptc_pkg::OP_NEXT, '0, '0, t0 - 32'd1, '0);
    send_word(cptc_pkg::OP_NEXT, '0, '0, t0, '0);
    send_word(cptc_pkg::OP_NEXT, '0, '0, t0 + 32'd100, '0);
    send_word(cptc_pkg::OP_NEXT, '0, '0, t0 + 32'd250, '0);
    // freeze with zero job, wrong job, then the right one
    send_word(cptc_pkg::OP_FREEZE, '0, '0, t0 + 32'd300, '0);
    send_word(cptc_pkg::OP_FREEZE, 32'd5, '0, t0 + 32'd300, '0);
    send_word(cptc_pkg::OP_FREEZE, 32'hFFFF_FFFF, '0, t0 + 32'd300, '0);
    send_word(cptc_pkg::OP_NEXT, '0, '0, t0 + 32'd1000, '0);
    send_word(cptc_pkg::OP_ADD, 32'hFFFF_FFFF, '0, t0 + 32'd1000, 24'h00_0004);
    // unused opcodes change nothing
    send_word(OP_SPARE0, $urandom(), $urandom(), $urandom(), rand_tgt());
    send_word(OP_SPARE1, $urandom(), $urandom(), $urandom(), rand_tgt());
    send_word(OP_SPARE2, $urandom(), $urandom(), $urandom(), rand_tgt());
    // deadline across the time wrap; add past it skips expiry
    send_word(cptc_pkg::OP_BEGIN, 32'd7, 32'h20, 32'hFFFF_FFF0, '0);
    send_word(cptc_pkg::OP_ADD, 32'd7, '0, 32'h20, 24'h00_0003);
    send_word(cptc_pkg::OP_POLL, '0, '0, 32'h10, '0);
    send_word(cptc_pkg::OP_NEXT, '0, '0, 32'h400, '0);
  endtask

  // Fill the table past capacity, then dispatch it around more than once
  task automatic run_fill(logic [cptc_pkg::JobW-1:0] job);
    logic [cptc_pkg::TgtW-1:0] base;
    base = rand_tgt();
    for (int k = 1; k <= 70; k++) begin
      send_word(cptc_pkg::OP_ADD, job, '0, clock_ms, {base[23:7], 7'(k)});
      if (k % 9 == 0)
        send_word(cptc_pkg::OP_ADD, job, '0, clock_ms, {base[23:7], 7'(k - 3)});
    end
    for (int k = 0; k < 80; k++) begin
      clock_ms += pace_ms + $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) send_word(cptc_pkg::OP_POLL, '0, '0, clock_ms, '0);
      else send_word(cptc_pkg::OP_NEXT, job, '0, clock_ms, '0);
    end
  endtask

  task automatic run_campaign();
    logic [cptc_pkg::JobW-1:0]  job;
    logic [cptc_pkg::JobW-1:0]  req_job;
    logic [cptc_pkg::TimeW-1:0] dur;
    logic [cptc_pkg::TgtW-1:0]  pool;
    logic [cptc_pkg::TgtW-1:0]  tgt;
    int                         pick;
    int                         n_ops;
    bit                         fill;
    job = $urandom();
    if (job == 0) job = 32'd1;
    pool = rand_tgt();
    fill = ($urandom_range(0, 99) < 12);
    if ($urandom_range(0, 3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    else clock_ms = $urandom();
    if (fill) dur = (dur_cap > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : dur_cap;
    else dur = pick_duration();
    send_word(cptc_pkg::OP_BEGIN, job, dur, clock_ms, rand_tgt());
    if (fill) begin
      run_fill(job);
      return;
    end
    n_ops = $urandom_range(5, 40);
    for (int n = 0; n < n_ops; n++) begin
      clock_ms += next_step();
      pick = $urandom_range(0, 99);
      req_job = ($urandom_range(0, 9) == 0) ? job ^ (32'd1 << $urandom_range(0, 31)) : job;
      if (pick < 40) begin
        case ($urandom_range(0, 9))
          0: tgt = '0;
          1, 2, 3: tgt = rand_tgt();
          default: tgt = pool ^ cptc_pkg::TgtW'($urandom_range(1, 12));
        endcase
        send_word(cptc_pkg::OP_ADD, req_job, $urandom(), clock_ms, tgt);
      end else if (pick < 70) begin
        send_word(cptc_pkg::OP_NEXT, $urandom(), $urandom(), clock_ms, rand_tgt());
      end else if (pick < 80) begin
        send_word(cptc_pkg::OP_POLL, $urandom(), $urandom(), clock_ms, rand_tgt());
      end else if (pick < 84) begin
        if ($urandom_range(0, 4) == 0) req_job = '0;
        send_word(cptc_pkg::OP_FREEZE, req_job, $urandom(), clock_ms, rand_tgt());
      end else if (pick < 93) begin
        send_word(cptc_pkg::OpW'(cptc_pkg::OP_ADD +
                                 $urandom_range(0, OP_SPARE2 - cptc_pkg::OP_ADD)),
                  $urandom(), $urandom(), $urandom(), rand_tgt());
      end else begin
        // broken begin: zero job, zero duration or duration over the cap
        case ($urandom_range(0, 2))
          0: send_word(cptc_pkg::OP_BEGIN, '0, pick_duration(), clock_ms, rand_tgt());
          1: send_word(cptc_pkg::OP_BEGIN, $urandom(), '0, clock_ms, rand_tgt());
          default: begin
            if (dur_cap == 32'hFFFF_FFFF)
              send_word(cptc_pkg::OP_BEGIN, '0, $urandom(), clock_ms, rand_tgt());
            else
              send_word(cptc_pkg::OP_BEGIN, $urandom(),
                        dur_cap + 32'd1 + $urandom_range(0, 32'hFFFF_FFFE - dur_cap),
                        clock_ms, rand_tgt());
          end
        endcase
      end
    end
  endtask

  task automatic run_random(int count);
    int start;
    start = accepted;
    while (accepted - start < count) run_campaign();
  endtask

  initial begin
    int drain;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings; sender idles lightly, receiver heavily
    send_idle_pct = 20;
    recv_idle_pct = 64;
    run_directed();
    run_random(500);

    // fastest pacing, widest duration cap; idling swapped
    load_config(16'd1, 32'hFFFF_FFFF);
    send_idle_pct = 64;
    recv_idle_pct = 20;
    run_random(500);

    // slowest pacing, tightest cap; no idling from here on
    load_config(16'hFFFF, 32'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(300);

    load_config(cptc_pkg::IntvW'($urandom_range(2, 3000)),
                $urandom_range(100000, 32'h7FFF_FFFF));
    run_random(500);

    // drain outstanding status words, then let the pipeline go quiet
    @(negedge clk);
    in_valid = 1'b0;
    drain = 0;
    while (tracker.owed_status.size() > 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (16) @(posedge clk);
    if (tracker.owed_status.size() > 0) begin
      $error("%0d status words never arrived", tracker.owed_status.size());
      tracker.errors++;
    end
    if (tracker.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/cptc_pkg.sv
hdl/cptc_tbl.sv
hdl/cptc_seq.sv
hdl/paced_round_robin_target_campaign_core.sv
hdl/cptc_chk.sv
tb/tb.sv
